// File: hw/rtl/lsts_pkg.sv
// Shared codes and types for the least served thread selector.
package lsts_pkg;

  // Slot state codes as held in the slot table
  localparam logic [1:0] SLOT_EMPTY    = 2'd0;
  localparam logic [1:0] SLOT_RUNNABLE = 2'd1;
  localparam logic [1:0] SLOT_BLOCKED  = 2'd2;
  localparam logic [1:0] SLOT_UNDEF    = 2'd3;

  // Transaction kinds carried on the input tuser
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Fixed field widths of the stream payloads
  localparam int SLOT_FIELD_W = 4;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 8;
  localparam int OUT_USER_W   = 2;

  // Control strobes from the sequencer to the slot table
  typedef struct packed {
    logic rd_en;
    logic st_wr;
    logic cnt_wr;
  } tbl_ctrl_t;

endpackage

// File: hw/rtl/lsts_table.sv
// Slot table: state and run count memories with per-slot written flags.
module lsts_table #(
  parameter int NUM_SLOTS  = 16,
  parameter int COUNT_BITS = 32,
  parameter int SLOT_W     = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lsts_pkg::tbl_ctrl_t   ctrl,
  input  logic [SLOT_W-1:0]     rd_addr,
  input  logic [SLOT_W-1:0]     wr_addr,
  input  logic [1:0]            st_wdata,
  input  logic [COUNT_BITS-1:0] cnt_wdata,
  output logic [1:0]            st_rdata,
  output logic [COUNT_BITS-1:0] cnt_rdata
);
  import lsts_pkg::*;

  logic [1:0]            st_mem  [NUM_SLOTS];
  logic [COUNT_BITS-1:0] cnt_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  written;
  logic [1:0]            st_q;
  logic                  written_q;

  // Write and read the memories; read data is registered
  always_ff @(posedge clk) begin
    if (ctrl.st_wr) begin
      st_mem[wr_addr] <= st_wdata;
    end
    if (ctrl.cnt_wr) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    if (ctrl.rd_en) begin
      st_q      <= st_mem[rd_addr];
      cnt_rdata <= cnt_mem[rd_addr];
    end
  end

  // Track which slots have been written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (ctrl.st_wr) begin
        written[wr_addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        written_q <= written[rd_addr];
      end
    end
  end

  // An unwritten slot reads as empty
  assign st_rdata = written_q ? st_q : SLOT_EMPTY;

endmodule

// File: hw/rtl/lsts_seq.sv
// Sequencer: slot scan with a shared count compare, commit and table writes.
module lsts_seq #(
  parameter int NUM_SLOTS  = 16,
  parameter int COUNT_BITS = 32,
  parameter int SLOT_W     = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [lsts_pkg::SLOT_FIELD_W-1:0] in_slot,
  input  logic [1:0]                    in_state,
  output lsts_pkg::tbl_ctrl_t           ctrl,
  output logic [SLOT_W-1:0]             rd_addr,
  output logic [SLOT_W-1:0]             wr_addr,
  output logic [1:0]                    st_wdata,
  output logic [COUNT_BITS-1:0]         cnt_wdata,
  input  logic [1:0]                    st_rdata,
  input  logic [COUNT_BITS-1:0]         cnt_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [lsts_pkg::SLOT_FIELD_W-1:0] res_slot,
  output logic                          res_fell_back,
  output logic                          res_no_thread
);
  import lsts_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_TAIL   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [SLOT_W-1:0]     scan_idx;
  logic [SLOT_W-1:0]     rd_idx;
  logic                  rd_vld;
  logic [SLOT_W-1:0]     current;
  logic                  found;
  logic [SLOT_W-1:0]     best_idx;
  logic [COUNT_BITS-1:0] best_cnt;
  logic                  occ_found;
  logic [SLOT_W-1:0]     occ_idx;
  logic [COUNT_BITS-1:0] occ_cnt;
  logic                  take_best;
  logic                  take_occ;
  logic [SLOT_W-1:0]     pick;
  logic [COUNT_BITS-1:0] pick_cnt;
  logic [31:0]           slot_ext;
  logic [31:0]           pick_ext;
  logic                  slot_in_range;
  logic                  any_found;

  assign slot_ext      = 32'(in_slot);
  assign slot_in_range = (slot_ext < NUM_SLOTS);
  assign any_found     = found || occ_found;

  // Shared compare: runnable, not current, count no greater than best so far
  assign take_best = rd_vld && (st_rdata == SLOT_RUNNABLE) && (rd_idx != current) &&
                     (!found || (cnt_rdata <= best_cnt));
  assign take_occ  = rd_vld && (st_rdata != SLOT_EMPTY) && !occ_found;

  // Choose the winner or fall back to the lowest occupied slot
  assign pick     = found ? best_idx : occ_idx;
  assign pick_cnt = found ? best_cnt : occ_cnt;
  assign pick_ext = 32'(pick);

  assign res_slot      = any_found ? pick_ext[SLOT_FIELD_W-1:0] : '0;
  assign res_fell_back = !found && occ_found;
  assign res_no_thread = !any_found;

  assign in_ready = (state == S_IDLE);
  assign rd_addr  = scan_idx;

  // Sequence control and table strobes
  always_comb begin
    state_next = state;
    ctrl       = '0;
    wr_addr    = pick;
    st_wdata   = SLOT_EMPTY;
    cnt_wdata  = pick_cnt + COUNT_BITS'(1);
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_WRITE) begin
            ctrl.st_wr  = slot_in_range;
            ctrl.cnt_wr = slot_in_range;
            wr_addr     = slot_ext[SLOT_W-1:0];
            st_wdata    = (in_state == SLOT_UNDEF) ? SLOT_BLOCKED : in_state;
            cnt_wdata   = '0;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctrl.rd_en = 1'b1;
        if (scan_idx == LAST_SLOT) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (res_ready) begin
          res_valid   = 1'b1;
          ctrl.cnt_wr = any_found;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_vld    <= 1'b0;
      current   <= '0;
      found     <= 1'b0;
      occ_found <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN);
      if (state == S_IDLE && in_valid && in_action == ACT_TICK) begin
        found     <= 1'b0;
        occ_found <= 1'b0;
      end else begin
        if (take_best) begin
          found <= 1'b1;
        end
        if (take_occ) begin
          occ_found <= 1'b1;
        end
      end
      if (state == S_COMMIT && res_ready && any_found) begin
        current <= pick;
      end
    end
  end

  // Scan address, read index and best candidates
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + SLOT_W'(1);
    end
    rd_idx <= scan_idx;
    if (take_best) begin
      best_idx <= rd_idx;
      best_cnt <= cnt_rdata;
    end
    if (take_occ) begin
      occ_idx <= rd_idx;
      occ_cnt <= cnt_rdata;
    end
  end

endmodule

// File: hw/rtl/least_served_thread_selector.sv
// Top level of the least served thread selector with its output register.
//
// Usage:
//   Input stream s_axis_*: one transaction per item. tuser is the action
//   (0 = scheduling tick, 1 = write slot state). A write sets one slot's
//   state and clears its run count; it gives no result.
//   A tick scans every slot and returns one result on m_axis_*: the chosen
//   slot in tdata, and in tuser the fallback and no-thread flags.
//   A tick's result is loaded into the output register after the scan, and
//   the next item is taken only once the tick has committed its result.
//   The scan reads one slot per cycle through a single table read port
//   into one shared count comparator.
//   Reset clears the state machine, the current slot and the per-slot
//   written flags, so every slot reads as empty; no clearing pass is run.
//   When the receiver stalls, the result holds in the output register and
//   a further write or tick is still taken; a second tick waits at the end
//   of its scan until the register is free.
module least_served_thread_selector #(
  parameter int NUM_SLOTS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [3:0] slot, [5:4] slot_state, [7:6] zero
  input  logic [lsts_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] action
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [3:0] next_slot, [7:4] zero
  output logic [lsts_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [0] fell_back, [1] no_thread
  output logic [lsts_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
  import lsts_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);

  tbl_ctrl_t               ctrl;
  logic [SLOT_W-1:0]       rd_addr;
  logic [SLOT_W-1:0]       wr_addr;
  logic [1:0]              st_wdata;
  logic [COUNT_BITS-1:0]   cnt_wdata;
  logic [1:0]              st_rdata;
  logic [COUNT_BITS-1:0]   cnt_rdata;
  logic                    res_valid;
  logic                    res_ready;
  logic [SLOT_FIELD_W-1:0] res_slot;
  logic                    res_fell_back;
  logic                    res_no_thread;

  lsts_seq #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .SLOT_W     (SLOT_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_action     (s_axis_tuser),
    .in_slot       (s_axis_tdata[SLOT_FIELD_W-1:0]),
    .in_state      (s_axis_tdata[SLOT_FIELD_W+1:SLOT_FIELD_W]),
    .ctrl          (ctrl),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .st_wdata      (st_wdata),
    .cnt_wdata     (cnt_wdata),
    .st_rdata      (st_rdata),
    .cnt_rdata     (cnt_rdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_slot      (res_slot),
    .res_fell_back (res_fell_back),
    .res_no_thread (res_no_thread)
  );

  lsts_table #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .SLOT_W     (SLOT_W)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .st_wdata  (st_wdata),
    .cnt_wdata (cnt_wdata),
    .st_rdata  (st_rdata),
    .cnt_rdata (cnt_rdata)
  );

  // Output register: free when empty or when the receiver takes the transaction
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_axis_tdata <= {(OUT_DATA_W - SLOT_FIELD_W)'(0), res_slot};
      m_axis_tuser <= {res_no_thread, res_fell_back};
    end
  end

endmodule
